>>> design/far_field_steering_vector_macros.svh
// Assertion macros for the far-field steering vector block.
// Expects signals named clk and rst_n in the module that includes this file.
`ifndef FAR_FIELD_STEERING_VECTOR_MACROS_SVH
`define FAR_FIELD_STEERING_VECTOR_MACROS_SVH

// same-cycle implication
`define FFSV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ffsv_pkg.sv
// Shared types and constants for the far-field steering vector block.
// No dependencies.
package ffsv_pkg;

  typedef struct packed {
    logic valid;
    logic zero;
    logic wr;
  } ctl_t;

  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int CW              = 34;
  localparam int ZW              = 33;

  localparam logic [23:0] PHASE_SCALE_RST = 24'd1528560;

  localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [ZW-1:0] HALF_TURN    = 33'sd2147483648;

  localparam logic signed [ZW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81
  };

endpackage

>>> design/far_field_steering_vector.sv
// Far-field steering vector: one complex coefficient per (source, mic, bin) item.
// Depends on ffsv_pkg and far_field_steering_vector_macros.svh.
//
// Usage:
//   Input: drive in_* fields with start high; the item is taken at a rising edge
//   where start is high and busy is low. busy is high only while rst_n is low,
//   so an item can enter on every cycle.
//   Output: out_valid marks a result for exactly one cycle together with
//   out_steer_real, out_steer_imag and out_write_valid. The receiver cannot
//   stall; results appear in input order.
//   Throughput: one item per cycle. The depth is set by the product chain for
//   the phase (5 ranks), the quadrant fold (1 rank), twelve CORDIC ranks of two
//   micro-rotations each, and the gain multiply and rounding (2 ranks).
//   Config: cfg_phase_scale is written when cfg_valid and cfg_ready are high;
//   write it only while no item is in flight. cfg_ready is high out of reset.
//   Reset (synchronous, rst_n low) empties the pipeline and restores the
//   default phase scale.
`include "far_field_steering_vector_macros.svh"

module far_field_steering_vector #(
  parameter int MAX_BINS = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_track_active,
  input  logic               in_mask_on,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic signed [15:0] in_mic_x,
  input  logic signed [15:0] in_mic_y,
  input  logic signed [15:0] in_mic_z,
  input  logic        [15:0] in_gain_in,
  input  logic        [8:0]  in_bin_index,
  output logic               out_valid,
  output logic signed [15:0] out_steer_real,
  output logic signed [15:0] out_steer_imag,
  output logic               out_write_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [23:0] cfg_phase_scale
);
  import ffsv_pkg::*;

  localparam int LAT = 6 + CORDIC_STAGES + 2;

  logic        in_acc;
  logic        bin_oor;
  logic [23:0] phase_scale_r;

  ctl_t        ctl_r  [LAT];
  logic [15:0] gain_r [LAT-2];

  logic signed [31:0] prod_x_r, prod_y_r, prod_z_r;
  logic        [8:0]  bin1_r, bin2_r;
  logic signed [33:0] dist_r;
  logic signed [42:0] db_r;
  logic signed [43:0] db_nxt;
  logic        [45:0] lo_prod_r;
  logic        [30:0] hi_prod_r;
  logic        [30:0] hi_word;
  logic        [54:0] hi_full;
  logic        [52:0] psum_nxt;
  logic        [15:0] phase_r;
  logic signed [ZW-1:0] z0_nxt;

  logic signed [CW-1:0] cx_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] cy_r [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz_r [CORDIC_STAGES+1];

  logic signed [50:0] gx_r, gy_r;
  logic signed [50:0] rx_nxt, ry_nxt;
  logic signed [15:0] sat_x_nxt, sat_y_nxt;
  logic signed [15:0] steer_real_r, steer_imag_r;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign in_acc    = start & ~busy;
  assign bin_oor   = ({23'd0, in_bin_index} >= 32'(MAX_BINS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_scale_r <= PHASE_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      phase_scale_r <= cfg_phase_scale;
    end
  end

  // control chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[0].valid <= in_acc;
      ctl_r[0].zero  <= ~in_track_active | ~in_mask_on | bin_oor;
      ctl_r[0].wr    <= ~in_track_active | (in_mask_on & ~bin_oor);
      for (int k = 1; k < LAT; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    gain_r[0] <= in_gain_in;
    for (int k = 1; k < LAT-2; k++) begin
      gain_r[k] <= gain_r[k-1];
    end
  end

  // phase: dot product, bin and scale products, rounding
  assign db_nxt  = dist_r * $signed({1'b0, bin2_r});
  assign hi_word = {{10{db_r[42]}}, db_r[42:22]};
  assign hi_full = hi_word * phase_scale_r;
  assign psum_nxt = {7'd0, lo_prod_r} + {hi_prod_r, 22'd0} + (53'd1 << 36);

  always_ff @(posedge clk) begin
    prod_x_r  <= in_dir_x * in_mic_x;
    prod_y_r  <= in_dir_y * in_mic_y;
    prod_z_r  <= in_dir_z * in_mic_z;
    bin1_r    <= in_bin_index;
    dist_r    <= 34'(prod_x_r) + 34'(prod_y_r) + 34'(prod_z_r);
    bin2_r    <= bin1_r;
    db_r      <= db_nxt[42:0];
    lo_prod_r <= db_r[21:0] * phase_scale_r;
    hi_prod_r <= hi_full[30:0];
    phase_r   <= psum_nxt[52:37];
  end

  // fold into [-quarter, quarter] turn
  assign z0_nxt = $signed({phase_r[15], phase_r, 16'd0});

  always_ff @(posedge clk) begin
    cy_r[0] <= '0;
    priority if (z0_nxt > QUARTER_TURN) begin
      cx_r[0] <= -CORDIC_GAIN;
      cz_r[0] <= z0_nxt - HALF_TURN;
    end else if (z0_nxt < -QUARTER_TURN) begin
      cx_r[0] <= -CORDIC_GAIN;
      cz_r[0] <= z0_nxt + HALF_TURN;
    end else begin
      cx_r[0] <= CORDIC_GAIN;
      cz_r[0] <= z0_nxt;
    end
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    logic signed [CW-1:0] x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      logic signed [CW-1:0] xt, yt;
      x_nxt = cx_r[s];
      y_nxt = cy_r[s];
      z_nxt = cz_r[s];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        xt = x_nxt >>> (s * STEPS_PER_STAGE + k);
        yt = y_nxt >>> (s * STEPS_PER_STAGE + k);
        if (z_nxt >= 0) begin
          x_nxt = x_nxt - yt;
          y_nxt = y_nxt + xt;
          z_nxt = z_nxt - ATAN_TURNS[s * STEPS_PER_STAGE + k];
        end else begin
          x_nxt = x_nxt + yt;
          y_nxt = y_nxt - xt;
          z_nxt = z_nxt + ATAN_TURNS[s * STEPS_PER_STAGE + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      cx_r[s+1] <= x_nxt;
      cy_r[s+1] <= y_nxt;
      cz_r[s+1] <= z_nxt;
    end
  end

  // gain, round half up, saturate
  assign rx_nxt = (gx_r + (51'sd1 <<< 29)) >>> 30;
  assign ry_nxt = (gy_r + (51'sd1 <<< 29)) >>> 30;

  always_comb begin
    priority if (rx_nxt > 51'sd32767) begin
      sat_x_nxt = 16'sh7FFF;
    end else if (rx_nxt < -51'sd32768) begin
      sat_x_nxt = -16'sh8000;
    end else begin
      sat_x_nxt = rx_nxt[15:0];
    end
    priority if (ry_nxt > 51'sd32767) begin
      sat_y_nxt = 16'sh7FFF;
    end else if (ry_nxt < -51'sd32768) begin
      sat_y_nxt = -16'sh8000;
    end else begin
      sat_y_nxt = ry_nxt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    gx_r <= cx_r[CORDIC_STAGES] * $signed({1'b0, gain_r[LAT-3]});
    gy_r <= cy_r[CORDIC_STAGES] * $signed({1'b0, gain_r[LAT-3]});
    steer_real_r <= ctl_r[LAT-2].zero ? 16'sd0 : sat_x_nxt;
    steer_imag_r <= ctl_r[LAT-2].zero ? 16'sd0 : sat_y_nxt;
  end

  assign out_valid       = ctl_r[LAT-1].valid;
  assign out_write_valid = ctl_r[LAT-1].wr;
  assign out_steer_real  = steer_real_r;
  assign out_steer_imag  = steer_imag_r;

  `FFSV_ASSERT_NOW(a_latency, 1'b1, out_valid == $past(start && !busy, LAT), "result strobe does not match item taken LAT cycles earlier")
  `FFSV_ASSERT_NOW(a_keep_zero, out_valid && !out_write_valid, out_steer_real == 16'sd0 && out_steer_imag == 16'sd0, "kept entry carries nonzero value")
  `FFSV_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, phase_scale_r == $past(cfg_phase_scale), "phase scale not updated by write")
  `FFSV_ASSERT_NOW(a_idle_cordic, ctl_r[LAT-1].valid && ctl_r[LAT-1].zero, out_steer_real == 16'sd0, "zeroed item shows nonzero real part")

endmodule

>>> tb/far_field_steering_vector_tb.sv
// Self-checking bench for far_field_steering_vector: directed and random
// (source, mic, bin) items against a bit-exact CORDIC steering predictor.
// Needs only the block's RTL (and the package and header it pulls in).
module far_field_steering_vector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          BIN_LIMIT  = 512;
  localparam logic [23:0] PS_DEFAULT = 24'd1528560;
  localparam longint      ROT_GAIN   = 64'sd652032874;
  localparam longint      QTR        = 64'sd1073741824;
  localparam longint      HALF       = 64'sd2147483648;
  localparam longint      ROUND_Q30  = 64'sd536870912;
  localparam int          LIMIT      = 200000;
  localparam longint      ROT_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic               track_active;
    logic               mask_on;
    logic signed [15:0] dir_x, dir_y, dir_z;
    logic signed [15:0] mic_x, mic_y, mic_z;
    logic        [15:0] gain;
    logic        [8:0]  bin;
  } triple_t;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               wr;
  } coef_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start = 1'b0;
  logic               busy;
  logic               in_track_active = 1'b0;
  logic               in_mask_on = 1'b0;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [15:0] in_mic_x = '0, in_mic_y = '0, in_mic_z = '0;
  logic        [15:0] in_gain_in = '0;
  logic        [8:0]  in_bin_index = '0;
  logic               out_valid;
  logic signed [15:0] out_steer_real, out_steer_imag;
  logic               out_write_valid;
  logic               cfg_valid;
  logic               cfg_ready;
  logic        [23:0] cfg_phase_scale;

  triple_t     triple_q[$];
  coef_t       steer_q[$];
  triple_t     cur;
  logic [23:0] scale_now;
  int          idle_pct;
  int unsigned n_loaded = 0, n_sent = 0, n_taken = 0;
  int unsigned errs = 0;
  int unsigned cycles = 0;

  far_field_steering_vector #(.MAX_BINS(BIN_LIMIT)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_track_active(in_track_active), .in_mask_on(in_mask_on),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_mic_x(in_mic_x), .in_mic_y(in_mic_y), .in_mic_z(in_mic_z),
    .in_gain_in(in_gain_in), .in_bin_index(in_bin_index),
    .out_valid(out_valid), .out_steer_real(out_steer_real),
    .out_steer_imag(out_steer_imag), .out_write_valid(out_write_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_phase_scale(cfg_phase_scale)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic coef_t steer_coef(triple_t t, logic [23:0] scale);
    coef_t              c;
    longint             dot_sum, x, y, z, nx, ny, g;
    longint unsigned    p;
    logic signed [31:0] ang;
    c.re = '0;
    c.im = '0;
    c.wr = !t.track_active;
    if (!t.track_active || !t.mask_on || t.bin >= BIN_LIMIT) return c;
    dot_sum = longint'(t.dir_x) * longint'(t.mic_x) + longint'(t.dir_y) * longint'(t.mic_y)
            + longint'(t.dir_z) * longint'(t.mic_z);
    p = dot_sum;
    p = p * t.bin * scale;
    p = p + (64'd1 << 36);
    ang = {p[52:37], 16'h0000};
    z = ang;
    x = ROT_GAIN;
    y = 0;
    if (z > QTR) begin
      z = z - HALF;
      x = -x;
    end else if (z < -QTR) begin
      z = z + HALF;
      x = -x;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - ROT_TURNS[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + ROT_TURNS[i];
      end
      x = nx;
      y = ny;
    end
    g = t.gain;
    c.re = clip16((x * g + ROUND_Q30) >>> 30);
    c.im = clip16((y * g + ROUND_Q30) >>> 30);
    c.wr = 1'b1;
    return c;
  endfunction

  function automatic triple_t mk(logic ta, logic mo, int dx, int dy, int dz,
                                 int mx, int my, int mz, int g, int b);
    triple_t t;
    t.track_active = ta;
    t.mask_on = mo;
    t.dir_x = 16'(dx);
    t.dir_y = 16'(dy);
    t.dir_z = 16'(dz);
    t.mic_x = 16'(mx);
    t.mic_y = 16'(my);
    t.mic_z = 16'(mz);
    t.gain = 16'(g);
    t.bin = 9'(b);
    return t;
  endfunction

  task automatic queue_triple(triple_t t);
    triple_q.push_back(t);
    n_loaded++;
  endtask

  task automatic flag(string msg);
    if (errs < 40) $display("mismatch @%0d: %s", cycles, msg);
    errs++;
  endtask

  task automatic drain();
    do @(negedge clk); while (n_taken != n_loaded || steer_q.size() != 0);
  endtask

  task automatic load_phase(logic [23:0] scale, int idle, int n);
    triple_t t;
    drain();
    idle_pct = idle;
    cfg_phase_scale <= scale;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    scale_now = scale;
    @(negedge clk);
    cfg_valid <= 1'b0;
    for (int k = 0; k < n; k++) begin
      t.track_active = $urandom_range(99) < 90;
      t.mask_on = $urandom_range(99) < 85;
      if ($urandom_range(3) == 0) begin
        t.dir_x = 16'($urandom);
        t.dir_y = 16'($urandom);
        t.dir_z = 16'($urandom);
        t.mic_x = 16'($urandom);
        t.mic_y = 16'($urandom);
        t.mic_z = 16'($urandom);
      end else begin
        t.dir_x = 16'($urandom_range(32768) - 16384);
        t.dir_y = 16'($urandom_range(32768) - 16384);
        t.dir_z = 16'($urandom_range(32768) - 16384);
        t.mic_x = 16'($urandom_range(8192) - 4096);
        t.mic_y = 16'($urandom_range(8192) - 4096);
        t.mic_z = 16'($urandom_range(8192) - 4096);
      end
      t.gain = ($urandom_range(9) < 7) ? 16'($urandom_range(16384)) : 16'($urandom);
      t.bin = 9'($urandom_range(511));
      queue_triple(t);
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (n_taken == n_sent) begin
      if (triple_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur = triple_q.pop_front();
        n_sent++;
        in_track_active <= cur.track_active;
        in_mask_on <= cur.mask_on;
        in_dir_x <= cur.dir_x;
        in_dir_y <= cur.dir_y;
        in_dir_z <= cur.dir_z;
        in_mic_x <= cur.mic_x;
        in_mic_y <= cur.mic_y;
        in_mic_z <= cur.mic_z;
        in_gain_in <= cur.gain;
        in_bin_index <= cur.bin;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    coef_t c;
    if (rst_n && out_valid) begin
      if (steer_q.size() == 0) begin
        flag("result with no item pending");
      end else begin
        c = steer_q.pop_front();
        if (out_steer_real !== c.re)
          flag($sformatf("steer_real %0d, want %0d", out_steer_real, c.re));
        if (out_steer_imag !== c.im)
          flag($sformatf("steer_imag %0d, want %0d", out_steer_imag, c.im));
        if (out_write_valid !== c.wr)
          flag($sformatf("write_valid %0b, want %0b", out_write_valid, c.wr));
      end
    end
    if (rst_n && start && !busy) begin
      steer_q.push_back(steer_coef(cur, scale_now));
      n_taken++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_phase_scale = '0;
    idle_pct = 12;
    scale_now = PS_DEFAULT;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_triple(mk(0, 1, 16384, 0, 0, 8192, 0, 0, 16384, 10));
    queue_triple(mk(0, 0, -32768, 32767, 0, 100, -100, 0, 65535, 511));
    queue_triple(mk(1, 0, 32767, 0, 0, 16384, 0, 0, 16384, 7));
    queue_triple(mk(1, 1, 32767, 0, 0, 16384, 0, 0, 16384, 1));
    queue_triple(mk(1, 1, -32768, -32768, -32768, -32768, -32768, -32768, 65535, 511));
    queue_triple(mk(1, 1, 32767, 32767, 32767, -32768, -32768, -32768, 65535, 511));
    queue_triple(mk(1, 1, 32767, 32767, 32767, 32767, 32767, 32767, 65535, 511));
    queue_triple(mk(1, 1, -32768, 32767, -32768, 32767, -32768, 32767, 16384, 256));
    queue_triple(mk(1, 1, 20000, -5000, 3000, 1000, 2000, -3000, 16384, 0));
    queue_triple(mk(1, 1, 0, 0, 0, 12345, -2222, 333, 16384, 300));
    queue_triple(mk(1, 1, 0, 0, 0, 0, 0, 0, 32768, 5));
    queue_triple(mk(1, 1, 0, 0, 0, 0, 0, 0, 65535, 5));
    queue_triple(mk(1, 1, 23170, 23170, 0, 4000, -4000, 2000, 0, 100));
    queue_triple(mk(1, 1, 23170, -23170, 0, 4000, 4000, 2000, 1, 100));
    queue_triple(mk(1, 1, 0, 32767, 0, 0, 16384, 0, 16384, 128));
    queue_triple(mk(1, 1, 0, 0, -32768, 0, 0, 8192, 65535, 255));
    queue_triple(mk(1, 1, 10000, 20000, -30000, -1500, 2500, 3500, 40000, 64));
    queue_triple(mk(1, 1, -1, -1, -1, -1, -1, -1, 16384, 511));

    load_phase(24'hFFFFFF, 12, 250);
    load_phase(24'h000000, 60, 200);
    load_phase(24'($urandom), 60, 250);
    load_phase(PS_DEFAULT, 0, 250);
    load_phase(24'($urandom_range(4000000)), 0, 280);
    drain();
    repeat (40) @(posedge clk);
    if (errs == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/ffsv_pkg.sv
design/far_field_steering_vector.sv
tb/far_field_steering_vector_tb.sv
